@@ sv/pfce_pkg.sv @@
`timescale 1ns / 1ps
package pfce_pkg;
   localparam int COLUMNS = 128;
   localparam int ROWS = 64;
   localparam int PAGES = (ROWS + 7) / 8;
   localparam int STORE_BYTES = COLUMNS * PAGES;
   localparam int ADDR_W = $clog2(STORE_BYTES);
   localparam int COL_W = $clog2(COLUMNS);
   localparam int DEC_W = 11;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      OP_SET_PIXEL   = 3'd0,
      OP_CLEAR_PIXEL = 3'd1,
      OP_CIRCLE      = 3'd2,
      OP_READ_BYTE   = 3'd3,
      OP_CLEAR_ALL   = 3'd4
   } opcode_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [6:0] pos_x;
      logic [5:0] pos_y;
      logic [2:0] page_sel;
      logic [6:0] circle_radius;
   } req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       clipped;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_PIXEL, CMD_CIRCLE, CMD_READ, CMD_CLEAR, CMD_NONE
   } cmd_kind_type;

   // classified command passed from front to back
   typedef struct packed {
      cmd_kind_type kind;
      logic         set_bit;
      logic         in_range;
      logic [7:0]   cx;
      logic [7:0]   cy;
      logic [6:0]   radius;
      logic [ADDR_W-1:0] addr;
      logic [2:0]   bit_sel;
   } cmd_type;
endpackage

@@ sv/pfce_front.sv @@
`timescale 1ns / 1ps
module pfce_front
   import pfce_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd_data
);
   cmd_type q_ff [QUEUE_DEPTH];
   logic [0:0] wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   cmd_type cls;
   logic push, pop;

   always_comb begin
      cls = '0;
      cls.cx = {1'b0, req_data.pos_x};
      cls.cy = {2'b0, req_data.pos_y};
      cls.radius = req_data.circle_radius;
      cls.bit_sel = req_data.pos_y[2:0];
      cls.set_bit = (req_data.opcode == OP_SET_PIXEL);
      cls.kind = CMD_NONE;
      case (req_data.opcode)
         OP_SET_PIXEL, OP_CLEAR_PIXEL: begin
            cls.kind = CMD_PIXEL;
            cls.in_range = (32'(req_data.pos_x) < COLUMNS) && (32'(req_data.pos_y) < ROWS);
            cls.addr = ADDR_W'(32'(req_data.pos_y[5:3]) * COLUMNS + 32'(req_data.pos_x));
         end
         OP_CIRCLE: cls.kind = CMD_CIRCLE;
         OP_READ_BYTE: begin
            cls.kind = CMD_READ;
            cls.in_range = (32'(req_data.pos_x) < COLUMNS) && (32'(req_data.page_sel) < PAGES);
            cls.addr = ADDR_W'(32'(req_data.page_sel) * COLUMNS + 32'(req_data.pos_x));
         end
         OP_CLEAR_ALL: cls.kind = CMD_CLEAR;
         default: cls.kind = CMD_NONE;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop = cmd_valid && cmd_ready;
   assign cmd_data = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) q_ff[wr_ptr_ff] <= cls;
   end
endmodule

@@ sv/pfce_back.sv @@
`timescale 1ns / 1ps
module pfce_back
   import pfce_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_RMW_RD, S_RMW_WR, S_CIRC_PT, S_CIRC_RD, S_CIRC_WR, S_RESP
   } state_type;

   logic [7:0] mem [STORE_BYTES];
   logic [7:0] rd_data_ff;
   logic [7:0] cur_byte;

   state_type  state_ff;
   cmd_type    cmd_ff;
   logic [ADDR_W-1:0] init_ff;
   logic       clear_cmd_ff;
   logic signed [8:0] a_ff, b_ff;
   logic signed [DEC_W-1:0] dec_ff;
   logic [2:0] oct_ff;
   logic       clip_ff;
   logic [7:0] rbyte_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_out_ff;
   logic       rsp_fire;
   logic [ADDR_W-1:0] addr_ff;
   logic [2:0] bit_ff;

   logic       we;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [7:0] wdata;

   logic signed [9:0] px, py;

   assign cur_byte = rd_data_ff;

   always_comb begin
      case (oct_ff)
         3'd0: begin px = 10'(cmd_ff.cx) + 10'(b_ff); py = 10'(cmd_ff.cy) - 10'(a_ff); end
         3'd1: begin px = 10'(cmd_ff.cx) + 10'(a_ff); py = 10'(cmd_ff.cy) - 10'(b_ff); end
         3'd2: begin px = 10'(cmd_ff.cx) - 10'(a_ff); py = 10'(cmd_ff.cy) - 10'(b_ff); end
         3'd3: begin px = 10'(cmd_ff.cx) - 10'(b_ff); py = 10'(cmd_ff.cy) - 10'(a_ff); end
         3'd4: begin px = 10'(cmd_ff.cx) - 10'(b_ff); py = 10'(cmd_ff.cy) + 10'(a_ff); end
         3'd5: begin px = 10'(cmd_ff.cx) - 10'(a_ff); py = 10'(cmd_ff.cy) + 10'(b_ff); end
         3'd6: begin px = 10'(cmd_ff.cx) + 10'(a_ff); py = 10'(cmd_ff.cy) + 10'(b_ff); end
         default: begin px = 10'(cmd_ff.cx) + 10'(b_ff); py = 10'(cmd_ff.cy) + 10'(a_ff); end
      endcase
   end

   logic on_scr;
   assign on_scr = (px >= 0) && (px < 10'(COLUMNS)) && (py >= 0) && (py < 10'(ROWS));

   always_comb begin
      we = 1'b0;
      waddr = addr_ff;
      wdata = cur_byte | (8'h01 << bit_ff);
      if (state_ff == S_INIT) begin
         we = 1'b1;
         waddr = init_ff;
         wdata = 8'h00;
      end else if (state_ff == S_RMW_WR && cmd_ff.kind == CMD_PIXEL && cmd_ff.in_range) begin
         we = 1'b1;
         wdata = cmd_ff.set_bit ? (cur_byte | (8'h01 << bit_ff))
                                : (cur_byte & ~(8'h01 << bit_ff));
      end else if (state_ff == S_CIRC_WR && on_scr) begin
         we = 1'b1;
      end
      raddr = addr_ff;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[raddr];
   end

   assign cmd_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_out_ff;
   assign rsp_fire = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   logic signed [DEC_W-1:0] dec_next;
   logic signed [8:0] b_next;
   always_comb begin
      b_next = b_ff;
      if (dec_ff < 0) begin
         dec_next = dec_ff + DEC_W'(4 * a_ff) + DEC_W'(6);
      end else begin
         dec_next = dec_ff + DEC_W'(4 * (a_ff - b_ff)) + DEC_W'(10);
         b_next = b_ff - 9'sd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_ff <= '0;
         clear_cmd_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_fire) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_INIT: begin
               init_ff <= init_ff + 1'b1;
               if (32'(init_ff) == STORE_BYTES - 1) begin
                  clear_cmd_ff <= 1'b0;
                  state_ff <= clear_cmd_ff ? S_RESP : S_IDLE;
               end
            end
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff <= cmd_data;
                  addr_ff <= cmd_data.addr;
                  bit_ff <= cmd_data.bit_sel;
                  rbyte_ff <= 8'h00;
                  clip_ff <= 1'b0;
                  a_ff <= '0;
                  b_ff <= 9'(cmd_data.radius);
                  dec_ff <= DEC_W'(3) - DEC_W'(2 * cmd_data.radius);
                  oct_ff <= '0;
                  case (cmd_data.kind)
                     CMD_PIXEL, CMD_READ: state_ff <= S_RMW_RD;
                     CMD_CIRCLE: state_ff <= S_CIRC_PT;
                     CMD_CLEAR: begin
                        init_ff <= '0;
                        clear_cmd_ff <= 1'b1;
                        state_ff <= S_INIT;
                     end
                     default: state_ff <= S_RESP;
                  endcase
               end
            end
            S_RMW_RD: state_ff <= S_RMW_WR;
            S_RMW_WR: begin
               if (cmd_ff.kind == CMD_READ && cmd_ff.in_range) rbyte_ff <= cur_byte;
               state_ff <= S_RESP;
            end
            S_CIRC_PT: begin
               if (a_ff > b_ff) begin
                  state_ff <= S_RESP;
               end else if (on_scr) begin
                  addr_ff <= ADDR_W'(32'(py[9:3]) * COLUMNS + 32'(px));
                  bit_ff <= py[2:0];
                  state_ff <= S_CIRC_RD;
               end else begin
                  clip_ff <= 1'b1;
                  state_ff <= S_CIRC_WR;
               end
            end
            S_CIRC_RD: state_ff <= S_CIRC_WR;
            S_CIRC_WR: begin
               oct_ff <= oct_ff + 1'b1;
               if (oct_ff == 3'd7) begin
                  dec_ff <= dec_next;
                  b_ff <= b_next;
                  a_ff <= a_ff + 9'sd1;
               end
               state_ff <= S_CIRC_PT;
            end
            S_RESP: begin
               if (rsp_fire) begin
                  rsp_out_ff.read_byte <= rbyte_ff;
                  rsp_out_ff.clipped <= clip_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ sv/page_framebuffer_circle_engine.sv @@
`timescale 1ns / 1ps
// Paged 128x64 monochrome frame store with set, clear, read, clear-all and midpoint
// circle commands. A set, clear or read goes through the single read-modify-write
// port; clear all sweeps every byte; a circle plots 8 pixels per step over
// radius/sqrt(2)+1 steps and skips the pixels that fall off screen. After reset a
// clearing pass runs before the first transaction is carried out.
module page_framebuffer_circle_engine
   import pfce_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   logic    cmd_valid, cmd_ready;
   cmd_type cmd_data;

   pfce_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .cmd_valid, .cmd_ready, .cmd_data
   );

   pfce_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   a_clip_only_circle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clipped |-> rsp_data.read_byte == 8'h00)
      else $error("clip flag with read data");
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response straight after reset");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped");
endmodule
